### sv/crsd_pkg.sv
// ----------------------------------------------------------------------------
// crsd_pkg: shared types and constants for the chunk snapshot decoder
// Holds payload structs, status and phase codes and header constants.
// ----------------------------------------------------------------------------
package crsd_pkg;

  localparam int unsigned BLOCKS_PER_CHUNK = 65536;

  localparam logic [31:0] SNAP_MAGIC   = 32'h3148_4C4D;
  localparam logic [31:0] SNAP_VERSION = 32'd1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_TRUNC  = 3'd1,
    ST_HEADER = 3'd2,
    ST_ZERO   = 3'd3,
    ST_OVER   = 3'd4,
    ST_SHORT  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_MAGIC    = 3'd0,
    PH_VERSION  = 3'd1,
    PH_X        = 3'd2,
    PH_Z        = 3'd3,
    PH_COUNT    = 3'd4,
    PH_VALUE    = 3'd5,
    PH_LENGTH   = 3'd6,
    PH_FINISHED = 3'd7
  } phase_e;

  typedef enum logic [0:0] {
    CFG_CHUNK_X = 1'b0,
    CFG_CHUNK_Z = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] data_word;
    logic        end_of_file;
  } in_t;

  typedef struct packed {
    logic        run_valid;
    logic [31:0] run_value;
    logic [15:0] run_start;
    logic [16:0] run_length;
    logic        done_res;
    status_e     status;
  } out_t;

  // One result request from the parser towards the output queue.
  typedef struct packed {
    logic valid;
    out_t res;
  } res_req_t;

endpackage

### sv/crsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// crsd_cfg_regs: configuration registers
// Expected chunk coordinates, written through the configuration channel.
// ----------------------------------------------------------------------------
module crsd_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  crsd_pkg::cfg_idx_e cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               cfg_ready_o,
  output logic [31:0]        chunk_x_o,
  output logic [31:0]        chunk_z_o
);

  logic [31:0] chunk_x_q, chunk_x_d;
  logic [31:0] chunk_z_q, chunk_z_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    chunk_x_d = chunk_x_q;
    chunk_z_d = chunk_z_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        crsd_pkg::CFG_CHUNK_X: chunk_x_d = cfg_data_i;
        crsd_pkg::CFG_CHUNK_Z: chunk_z_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_x_q <= '0;
      chunk_z_q <= '0;
    end else begin
      chunk_x_q <= chunk_x_d;
      chunk_z_q <= chunk_z_d;
    end
  end

  assign chunk_x_o = chunk_x_q;
  assign chunk_z_o = chunk_z_q;

endmodule

### sv/crsd_parser.sv
// ----------------------------------------------------------------------------
// crsd_parser: snapshot header and run parser
// Tracks the parse phase and fill cursor and forms at most one result per request.
// ----------------------------------------------------------------------------
module crsd_parser #(
  parameter int unsigned BlocksPerChunk = crsd_pkg::BLOCKS_PER_CHUNK
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  crsd_pkg::in_t      in_data_i,
  input  logic [31:0]        chunk_x_i,
  input  logic [31:0]        chunk_z_i,
  output crsd_pkg::res_req_t res_o
);

  localparam int unsigned CurW = $clog2(BlocksPerChunk + 1);
  localparam logic [32:0] Limit = 33'(BlocksPerChunk);

  crsd_pkg::phase_e phase_q, phase_d;
  logic             header_bad_q, header_bad_d;
  logic [31:0]      runs_q, runs_d;
  logic [CurW-1:0]  cursor_q, cursor_d;
  logic [31:0]      pending_q, pending_d;

  logic [31:0] word;
  logic        eof;
  logic [32:0] run_end;
  logic [31:0] cursor_ext;
  logic        run_zero;
  logic        run_over;
  logic        last_run;

  assign word       = in_data_i.data_word;
  assign eof        = in_data_i.end_of_file;
  assign cursor_ext = 32'(cursor_q);
  assign run_end    = {1'b0, cursor_ext} + {1'b0, word};
  assign run_zero   = (word == '0);
  assign run_over   = (run_end > Limit);
  assign last_run   = (runs_q == 32'd1);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (in_fire_i) begin
      if (eof) begin
        phase_d = crsd_pkg::PH_MAGIC;
      end else begin
        case (phase_q)
          crsd_pkg::PH_MAGIC:   phase_d = crsd_pkg::PH_VERSION;
          crsd_pkg::PH_VERSION: phase_d = crsd_pkg::PH_X;
          crsd_pkg::PH_X:       phase_d = crsd_pkg::PH_Z;
          crsd_pkg::PH_Z:       phase_d = crsd_pkg::PH_COUNT;
          crsd_pkg::PH_COUNT: begin
            if (header_bad_q || run_zero) phase_d = crsd_pkg::PH_FINISHED;
            else                          phase_d = crsd_pkg::PH_VALUE;
          end
          crsd_pkg::PH_VALUE:   phase_d = crsd_pkg::PH_LENGTH;
          crsd_pkg::PH_LENGTH: begin
            if (run_zero || run_over || last_run) phase_d = crsd_pkg::PH_FINISHED;
            else                                  phase_d = crsd_pkg::PH_VALUE;
          end
          default:              phase_d = crsd_pkg::PH_FINISHED;
        endcase
      end
    end
  end

  // Datapath state and result.
  always_comb begin
    header_bad_d = header_bad_q;
    runs_d       = runs_q;
    cursor_d     = cursor_q;
    pending_d    = pending_q;
    res_o        = '0;
    res_o.res.status = crsd_pkg::ST_OK;
    if (in_fire_i) begin
      if (eof) begin
        header_bad_d = 1'b0;
        runs_d       = '0;
        cursor_d     = '0;
        pending_d    = '0;
        if (phase_q != crsd_pkg::PH_FINISHED) begin
          res_o.valid        = 1'b1;
          res_o.res.done_res = 1'b1;
          res_o.res.status   = crsd_pkg::ST_TRUNC;
        end
      end else begin
        case (phase_q)
          crsd_pkg::PH_MAGIC:   if (word != crsd_pkg::SNAP_MAGIC) header_bad_d = 1'b1;
          crsd_pkg::PH_VERSION: if (word != crsd_pkg::SNAP_VERSION) header_bad_d = 1'b1;
          crsd_pkg::PH_X:       if (word != chunk_x_i) header_bad_d = 1'b1;
          crsd_pkg::PH_Z:       if (word != chunk_z_i) header_bad_d = 1'b1;
          crsd_pkg::PH_COUNT: begin
            if (header_bad_q) begin
              res_o.valid        = 1'b1;
              res_o.res.done_res = 1'b1;
              res_o.res.status   = crsd_pkg::ST_HEADER;
            end else begin
              runs_d   = word;
              cursor_d = '0;
              if (run_zero) begin
                res_o.valid        = 1'b1;
                res_o.res.done_res = 1'b1;
                res_o.res.status   = crsd_pkg::ST_SHORT;
              end
            end
          end
          crsd_pkg::PH_VALUE:   pending_d = word;
          crsd_pkg::PH_LENGTH: begin
            res_o.valid = 1'b1;
            if (run_zero) begin
              res_o.res.done_res = 1'b1;
              res_o.res.status   = crsd_pkg::ST_ZERO;
            end else if (run_over) begin
              res_o.res.done_res = 1'b1;
              res_o.res.status   = crsd_pkg::ST_OVER;
            end else begin
              cursor_d = run_end[CurW-1:0];
              runs_d   = runs_q - 32'd1;
              res_o.res.run_valid  = 1'b1;
              res_o.res.run_value  = pending_q;
              res_o.res.run_start  = cursor_ext[15:0];
              res_o.res.run_length = word[16:0];
              if (last_run) begin
                res_o.res.done_res = 1'b1;
                res_o.res.status   = (run_end == Limit) ? crsd_pkg::ST_OK
                                                        : crsd_pkg::ST_SHORT;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= crsd_pkg::PH_MAGIC;
      header_bad_q <= 1'b0;
      runs_q       <= '0;
      cursor_q     <= '0;
      pending_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      header_bad_q <= header_bad_d;
      runs_q       <= runs_d;
      cursor_q     <= cursor_d;
      pending_q    <= pending_d;
    end
  end

endmodule

### sv/crsd_out_fifo.sv
// ----------------------------------------------------------------------------
// crsd_out_fifo: two-entry result queue
// Registers results and decouples the output handshake from the input side.
// ----------------------------------------------------------------------------
module crsd_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crsd_pkg::res_req_t push_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crsd_pkg::out_t     out_data_o
);

  crsd_pkg::out_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i.valid;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push_i.valid} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_ptr_q] <= push_i.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### sv/chunk_rle_snapshot_decoder_top.sv
// ----------------------------------------------------------------------------
// chunk_rle_snapshot_decoder_top: chunk snapshot run-length decoder
// Parses a snapshot header and value/count pairs into run descriptors.
// ----------------------------------------------------------------------------
// Each result is registered in the output queue before it is offered.
// Throughput: one request per cycle; the parser updates in the cycle of
// acceptance and results sit in a two-entry queue in front of the output.
// Requests stall only when both queue entries are full.
// Reset clears the parser to expect a magic word, empties the queue and
// sets both expected coordinates to zero.
module chunk_rle_snapshot_decoder_top #(
  parameter int unsigned BlocksPerChunk = crsd_pkg::BLOCKS_PER_CHUNK
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  crsd_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crsd_pkg::out_t     out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  crsd_pkg::cfg_idx_e cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic               in_fire;
  logic               space;
  logic [31:0]        chunk_x;
  logic [31:0]        chunk_z;
  crsd_pkg::res_req_t res_req;

  assign in_ready_o = space;
  assign in_fire    = in_valid_i && space;

  crsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .chunk_x_o   (chunk_x),
    .chunk_z_o   (chunk_z)
  );

  crsd_parser #(
    .BlocksPerChunk (BlocksPerChunk)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .chunk_x_i (chunk_x),
    .chunk_z_i (chunk_z),
    .res_o     (res_req)
  );

  crsd_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_req),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/crsd_checker.sv
// ----------------------------------------------------------------------------
// crsd_checker: port-level checks for the snapshot decoder
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module crsd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input crsd_pkg::out_t out_data_o
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Reset empties the queue and opens the input.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("queue not empty during reset");

  // A result without a run carries zero run fields and a verdict.
  a_no_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_valid |->
      out_data_o.run_value == '0 && out_data_o.run_start == '0 &&
      out_data_o.run_length == '0 && out_data_o.done_res)
    else $error("verdict-only result with run fields set");

  // A status other than ok comes only with a verdict.
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == crsd_pkg::ST_OK)
    else $error("status given without a verdict");

  // An emitted run is never empty.
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.run_valid |-> out_data_o.run_length != '0)
    else $error("run of zero length emitted");

endmodule

bind chunk_rle_snapshot_decoder_top crsd_checker u_crsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
